[hw/rtl/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, operation codes,
// controller states and the command/status structs. No dependencies.
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;
    localparam int CW    = $clog2(DW + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_CMP = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_SUM,
        ST_GINIT,
        ST_GCD,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic sum;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic second;
    } sts_t;

endpackage

[hw/rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit: stream ports around the
// controller (rau_ctrl) and datapath (rau_datapath). Depends on rau_pkg.
//
//  channel | direction | tdata fields (low bit up)
//  s_      | in        | op[1:0] a_num[33:2] a_den[65:34] b_num[97:66] b_den[129:98]
//  m_      | out       | result_num[31:0] result_den[63:32] is_equal[64] overflow[65]
//
// One item at a time: the product states ST_MUL1 and ST_MUL2, a sum state, a gcd load
// state, a binary gcd of one step per cycle on double-width values, then a restoring
// divide of numerator and denominator in parallel; compare runs the gcd and divide
// once per fraction.
// aresetn is synchronous; a stalled result holds in the datapath registers.
module rational_arith_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // op, a_num, a_den, b_num, b_den, zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // result_num, result_den, is_equal, overflow, zero fill
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy, in_fire, out_fire;
    logic [31:0] rnum, rden;
    logic req, rovf;

    // accept a transfer only when idle
    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    rau_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_op(s_tdata[1:0]),
        .out_fire(out_fire), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
    );

    rau_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .sts(sts), .in_op(s_tdata[1:0]),
        .in_an(s_tdata[2 +: WIDTH]), .in_ad(s_tdata[34 +: WIDTH]),
        .in_bn(s_tdata[66 +: WIDTH]), .in_bd(s_tdata[98 +: WIDTH]),
        .res_num(rnum), .res_den(rden), .res_eq(req), .res_ovf(rovf)
    );

    assign m_tdata = {6'b0, rovf, req, rden, rnum};
endmodule

[hw/rtl/rau_datapath.sv]
// Datapath of the rational arithmetic unit: operand decode, products,
// binary gcd and two shared restoring dividers. Depends on rau_pkg.
module rau_datapath (
    input  logic                      aclk,
    input  rau_pkg::cmd_t             cmd,
    output rau_pkg::sts_t             sts,
    input  logic [1:0]                in_op,
    input  logic [rau_pkg::WIDTH-1:0] in_an,
    input  logic [rau_pkg::WIDTH-1:0] in_ad,
    input  logic [rau_pkg::WIDTH-1:0] in_bn,
    input  logic [rau_pkg::WIDTH-1:0] in_bd,
    output logic [31:0]               res_num,
    output logic [31:0]               res_den,
    output logic                      res_eq,
    output logic                      res_ovf
);
    import rau_pkg::*;

    logic [1:0]       op_reg;
    logic [WIDTH-1:0] m_an_reg, m_ad_reg, m_bn_reg, m_bd_reg;
    logic             s_an_reg, s_ad_reg, s_bn_reg, s_bd_reg;
    logic [DW-1:0]    p1_reg, p2_reg, p3_reg;
    logic [DW-1:0]    n_reg, d_reg;
    logic             nn_reg, dn_reg;
    logic             second_reg;
    logic [DW-1:0]    ra_n_reg, ra_d_reg;
    logic             ra_s_reg;
    logic [DW-1:0]    u_reg, v_reg, g_reg;
    logic [CW-1:0]    sh_reg;
    logic             gdone_reg;
    logic [DW-1:0]    qn_reg, qd_reg, rn_reg, rd_reg;
    logic [CW-1:0]    dcnt_reg;
    logic [31:0]      onum_reg, oden_reg;
    logic             oeq_reg, oovf_reg;

    function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // gcd step values
    logic [DW-1:0] vs, ga, gb;
    always_comb begin
        vs = v_reg;
        if (!v_reg[0]) vs = v_reg >> 1;
        ga = (u_reg > vs) ? vs : u_reg;
        gb = (u_reg > vs) ? u_reg : vs;
    end

    // divider trial subtraction for both quotients
    logic [DW:0] trn, trd;
    assign trn = {rn_reg, qn_reg[DW-1]} - {1'b0, g_reg};
    assign trd = {rd_reg, qd_reg[DW-1]} - {1'b0, g_reg};

    logic [DW-1:0] sum_mag;
    logic          sum_neg, x_neg, y_neg;
    always_comb begin
        x_neg = (s_an_reg ^ s_bd_reg) && p1_reg != '0;
        y_neg = (s_ad_reg ^ s_bn_reg) && p2_reg != '0;
        if (x_neg == y_neg) begin
            sum_mag = p1_reg + p2_reg; sum_neg = x_neg;
        end else if (p1_reg >= p2_reg) begin
            sum_mag = p1_reg - p2_reg; sum_neg = x_neg;
        end else begin
            sum_mag = p2_reg - p1_reg; sum_neg = y_neg;
        end
        if (sum_mag == '0) sum_neg = 1'b0;
    end

    // reduced sign/magnitude after division
    logic [DW-1:0] fn, fd;
    logic          fneg;
    localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);
    always_comb begin
        fn = (g_reg == '0) ? n_reg : qn_reg;
        fd = (g_reg == '0) ? d_reg : qd_reg;
        fneg = nn_reg ^ (dn_reg && fd != '0);
        if (fn == '0) fneg = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            s_an_reg <= in_an[WIDTH-1]; m_an_reg <= mag_of(in_an);
            s_ad_reg <= in_ad[WIDTH-1]; m_ad_reg <= mag_of(in_ad);
            s_bn_reg <= in_bn[WIDTH-1]; m_bn_reg <= mag_of(in_bn);
            s_bd_reg <= in_bd[WIDTH-1]; m_bd_reg <= mag_of(in_bd);
            second_reg <= 1'b0;
        end
        if (cmd.mul1) begin
            p1_reg <= (op_reg == OP_MUL) ? DW'(m_an_reg) * DW'(m_bn_reg)
                                         : DW'(m_an_reg) * DW'(m_bd_reg);
            p3_reg <= DW'(m_ad_reg) * DW'(m_bd_reg);
        end
        if (cmd.mul2) begin
            p2_reg <= DW'(m_ad_reg) * DW'(m_bn_reg);
        end
        if (cmd.sum) begin
            if (op_reg == OP_CMP) begin
                n_reg  <= second_reg ? DW'(m_bn_reg) : DW'(m_an_reg);
                nn_reg <= second_reg ? s_bn_reg : s_an_reg;
                d_reg  <= second_reg ? DW'(m_bd_reg) : DW'(m_ad_reg);
                dn_reg <= second_reg ? s_bd_reg : s_ad_reg;
            end else if (op_reg == OP_MUL) begin
                n_reg  <= p1_reg;
                nn_reg <= (s_an_reg ^ s_bn_reg) && p1_reg != '0;
                d_reg  <= p3_reg;
                dn_reg <= (s_ad_reg ^ s_bd_reg) && p3_reg != '0;
            end else begin
                n_reg  <= sum_mag;
                nn_reg <= sum_neg;
                d_reg  <= p3_reg;
                dn_reg <= (s_ad_reg ^ s_bd_reg) && p3_reg != '0;
            end
        end
        if (cmd.gcd_start) begin
            u_reg <= n_reg; v_reg <= d_reg; sh_reg <= '0; gdone_reg <= 1'b0;
            g_reg <= '0;
        end else if (cmd.gcd_step && !gdone_reg) begin
            // one binary gcd step per cycle
            if (u_reg == '0) begin
                g_reg <= v_reg; gdone_reg <= 1'b1;
            end else if (v_reg == '0) begin
                g_reg <= u_reg << sh_reg; gdone_reg <= 1'b1;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1; v_reg <= v_reg >> 1; sh_reg <= sh_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else begin
                u_reg <= ga; v_reg <= gb - ga;
            end
        end
        if (cmd.div_start) begin
            qn_reg <= n_reg; qd_reg <= d_reg;
            rn_reg <= '0; rd_reg <= '0; dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trn[DW]) begin
                rn_reg <= trn[DW-1:0]; qn_reg <= {qn_reg[DW-2:0], 1'b1};
            end else begin
                rn_reg <= {rn_reg[DW-2:0], qn_reg[DW-1]};
                qn_reg <= {qn_reg[DW-2:0], 1'b0};
            end
            if (!trd[DW]) begin
                rd_reg <= trd[DW-1:0]; qd_reg <= {qd_reg[DW-2:0], 1'b1};
            end else begin
                rd_reg <= {rd_reg[DW-2:0], qd_reg[DW-1]};
                qd_reg <= {qd_reg[DW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.fin) begin
            second_reg <= 1'b1;
            if (op_reg == OP_CMP && !second_reg) begin
                ra_n_reg <= fn; ra_d_reg <= fd; ra_s_reg <= fneg;
            end else begin
                onum_reg <= '0; oden_reg <= '0; oeq_reg <= 1'b0; oovf_reg <= 1'b0;
                if (op_reg == OP_CMP) begin
                    oeq_reg <= (ra_n_reg == fn) && (ra_s_reg == fneg) && (ra_d_reg == fd);
                end else if (op_reg != OP_NOP) begin
                    if (fd >= LIM || (fneg ? fn > LIM : fn >= LIM)) begin
                        oovf_reg <= 1'b1;
                    end else begin
                        onum_reg <= 32'(signed'(WIDTH'(fneg ? (~fn + 1'b1) : fn)));
                        oden_reg <= 32'(fd);
                    end
                end
            end
        end
    end

    assign sts.gcd_done = gdone_reg;
    assign sts.div_done = (dcnt_reg == CW'(DW));
    assign sts.second   = second_reg;
    assign res_num = onum_reg;
    assign res_den = oden_reg;
    assign res_eq  = oeq_reg;
    assign res_ovf = oovf_reg;
endmodule

[hw/rtl/rau_ctrl.sv]
// Controller of the rational arithmetic unit: sequences load, products,
// gcd, division and result. Depends on rau_pkg.
module rau_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [1:0]    in_op,
    input  logic          out_fire,
    input  rau_pkg::sts_t sts,
    output rau_pkg::cmd_t cmd,
    output logic          busy,
    output logic          out_valid
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   cmp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmp_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire) cmp_reg <= (in_op == OP_CMP);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_GINIT;
            ST_GINIT: state_next = ST_GCD;
            ST_GCD:   if (sts.gcd_done) state_next = ST_DIV;
            ST_DIV:   if (sts.div_done) state_next = ST_FIN;
            ST_FIN:   state_next = (cmp_reg && !sts.second) ? ST_SUM : ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.load = in_fire;
            ST_MUL1:  cmd.mul1 = 1'b1;
            ST_MUL2:  cmd.mul2 = 1'b1;
            ST_SUM:   cmd.sum  = 1'b1;
            ST_GINIT: cmd.gcd_start = 1'b1;
            ST_GCD: begin
                cmd.gcd_step  = 1'b1;
                cmd.div_start = sts.gcd_done;
            end
            ST_DIV:   cmd.div_step = !sts.div_done;
            ST_FIN:   cmd.fin = 1'b1;
            default: ;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    a_fin_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN |-> $past(sts.div_done)) else $error("fin before divide");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_fire |=> out_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == ST_IDLE) else $error("load while busy");
endmodule

[verif/tb_top.sv]
// Self-checking testbench for rational_arith_unit: drives fraction pairs with
// random burst gaps, predicts each result and compares it. Depends on rau_pkg.
`timescale 1ns / 100ps

module tb_top;
    import rau_pkg::*;

    localparam int  N_RANDOM  = 1800;
    localparam longint LIMIT  = 8000000;

    typedef struct packed {
        logic [31:0] b_den;
        logic [31:0] b_num;
        logic [31:0] a_den;
        logic [31:0] a_num;
        op_t         op;
    } frac_req_t;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
        logic        is_equal;
        logic        overflow;
    } frac_res_t;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } smag_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [135:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [71:0]   m_tdata;

    frac_req_t     pending_q[$];
    frac_res_t     expected_q[$];
    int            errors = 0;
    bit            stim_done = 1'b0;
    longint        cycle = 0;

    rational_arith_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic smag_t to_smag(logic [31:0] raw);
        smag_t r;
        r.neg = raw[WIDTH-1];
        r.mag = r.neg ? {32'd0, -raw} : {32'd0, raw};
        return r;
    endfunction

    function automatic smag_t smag_mul(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (x.neg != y.neg) && r.mag != 0;
        return r;
    endfunction

    function automatic smag_t smag_add(smag_t x, smag_t y);
        smag_t r;
        bit xn, yn;
        xn = x.neg && x.mag != 0;
        yn = y.neg && y.mag != 0;
        if (xn == yn) begin
            r.mag = x.mag + y.mag;
            r.neg = xn;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = xn;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = yn;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    // Euclid gives the same gcd value as the hardware's binary walk.
    function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
        logic [63:0] t;
        while (v != 0) begin
            t = u % v;
            u = v;
            v = t;
        end
        return u;
    endfunction

    function automatic void reduce_frac(inout smag_t n, inout smag_t d);
        logic [63:0] g;
        g = gcd64(n.mag, d.mag);
        if (g != 0) begin
            n.mag = n.mag / g;
            d.mag = d.mag / g;
        end
        if (d.neg && d.mag != 0) n.neg = !n.neg;
        d.neg = 1'b0;
        if (n.mag == 0) n.neg = 1'b0;
    endfunction

    function automatic frac_res_t predict_fraction(frac_req_t q);
        frac_res_t r;
        smag_t an, ad, bn, bd, rn, rd;
        logic [63:0] lim;
        r = '{default: '0};
        an = to_smag(q.a_num);
        ad = to_smag(q.a_den);
        bn = to_smag(q.b_num);
        bd = to_smag(q.b_den);
        lim = 64'd1 << (WIDTH - 1);
        case (q.op)
            OP_CMP: begin
                reduce_frac(an, ad);
                reduce_frac(bn, bd);
                r.is_equal = an.mag == bn.mag && an.neg == bn.neg && ad.mag == bd.mag;
                return r;
            end
            OP_ADD: rn = smag_add(smag_mul(an, bd), smag_mul(ad, bn));
            OP_MUL: rn = smag_mul(an, bn);
            default: return r;
        endcase
        rd = smag_mul(ad, bd);
        reduce_frac(rn, rd);
        if (rd.mag >= lim || (rn.neg ? rn.mag > lim : rn.mag >= lim)) begin
            r.overflow = 1'b1;
            return r;
        end
        r.num = rn.neg ? 32'(-rn.mag) : rn.mag[31:0];
        r.den = rd.mag[31:0];
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(0) - 32'($urandom_range(0, 3));
            3, 4: return 32'($urandom_range(0, 40)) - 32'd20;
            5: return 32'($urandom_range(0, 2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(op_t op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        frac_req_t q;
        q.op = op;
        q.a_num = an;
        q.a_den = ad;
        q.b_num = bn;
        q.b_den = bd;
        pending_q.push_back(q);
    endtask

    initial begin
        logic [31:0] k;
        // directed: extremes, each op, zero-over-zero, zero denominators, overflow
        push_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        push_item(OP_MUL, 32'd2, 32'd4, 32'd3, 32'd9);
        push_item(OP_CMP, 32'd2, 32'd4, -32'd1, -32'd2);
        push_item(OP_CMP, 32'd2, 32'd4, 32'd1, -32'd2);
        push_item(OP_NOP, 32'd5, 32'd7, 32'd1, 32'd1);
        push_item(OP_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
        push_item(OP_CMP, 32'd0, 32'd0, 32'd0, 32'd0);
        push_item(OP_MUL, 32'd5, 32'd0, -32'd3, 32'd1);
        push_item(OP_ADD, -32'd5, 32'd0, 32'd3, 32'd7);
        push_item(OP_MUL, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
        push_item(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        push_item(OP_CMP, 32'h8000_0000, -32'd1, 32'h8000_0000, -32'd1);
        push_item(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        push_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_ADD, 32'd3, -32'd4, 32'd3, 32'd4);
        push_item(OP_CMP, 32'd6, 32'd0, 32'd1, 32'd0);
        push_item(OP_CMP, 32'd0, 32'd5, 32'd0, -32'd9);
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(1, 50);
            if (i % 5 == 0) begin
                // scaled copies so compare often finds equality
                push_item(OP_CMP, rand_word() , rand_word(), 0, 0);
                pending_q[$].b_num = pending_q[$].a_num * k;
                pending_q[$].b_den = pending_q[$].a_den * ((i % 10 == 0) ? k : -k);
            end else begin
                push_item(op_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                          rand_word(), rand_word());
            end
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ---------------- driver: bursts with random gaps ----------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_fraction(frac_req_t'(s_tdata[129:0])));
                void'(pending_q.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                // advance to the next item or hold a gap
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, pending_q[0]};
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // ---------------- receiver stall pattern ----------------
    int stall_mode = 0;
    int mode_left = 0;
    int hold_off = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (cycle == 2000) begin
            // long hold-off so the sender backs up against s_tready
            hold_off <= 3000;
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 2000);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (cycle % 300) > 250;
            endcase
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        frac_res_t e;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                errors <= errors + 1;
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.num) begin
                    $error("result_num expected %h actual %h", e.num, m_tdata[31:0]);
                    errors <= errors + 1;
                end
                if (m_tdata[63:32] !== e.den) begin
                    $error("result_den expected %h actual %h", e.den, m_tdata[63:32]);
                    errors <= errors + 1;
                end
                if (m_tdata[64] !== e.is_equal) begin
                    $error("is_equal expected %b actual %b", e.is_equal, m_tdata[64]);
                    errors <= errors + 1;
                end
                if (m_tdata[65] !== e.overflow) begin
                    $error("overflow expected %b actual %b", e.overflow, m_tdata[65]);
                    errors <= errors + 1;
                end
            end
        end
    end

    // ---------------- end of run ----------------
    initial begin
        wait (stim_done && expected_q.size() == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("** rational_arith_unit: PASSED **");
        else
            $display("** rational_arith_unit: FAILED **");
        $finish;
    end

    initial begin
        wait (cycle >= LIMIT);
        $display("** rational_arith_unit: FAILED **");
        $finish;
    end

endmodule

[rational_arith_unit.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arith_unit.sv
verif/tb_top.sv
